[sv/salru_pkg.sv]
// ----------------------------------------------------------------------------
// salru_pkg
// shared types and constants of the set-associative true-lru tag store
// ----------------------------------------------------------------------------
`default_nettype none

package salru_pkg;

    // field widths of the stream words
    localparam int ADDR_W    = 64;
    localparam int OUTCOME_W = 2;
    localparam int VICTIM_W  = 58;
    localparam int RESULT_W  = OUTCOME_W + VICTIM_W;
    localparam int OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - RESULT_W;

    // lookup outcome codes
    typedef enum logic [OUTCOME_W-1:0] {
        OUTCOME_HIT   = 2'd0,
        OUTCOME_MISS  = 2'd1,
        OUTCOME_EVICT = 2'd2
    } outcome_t;

endpackage

`default_nettype wire

[sv/set_assoc_lru_tag_store.sv]
// ----------------------------------------------------------------------------
// set_assoc_lru_tag_store
// set-associative tag store with true-lru replacement, one lookup per word
//
//   channel  | dir | tdata bits (low first)                  | meaning
//   s_axis   | in  | [63:0] line_address                     | block address
//   m_axis   | out | [1:0] outcome, [59:2] victim_tag, pad 0 | lookup result
//
// one word per cycle sustained while m_axis is ready; a word's set row and tag
// are registered at the accepting edge, then compare / lru update / write-back
// and the output register take effect when the update stage advances.
// after reset the store is cleared one set row per cycle, with s_axis_tready
// low. the row just written is forwarded to the next lookup of the
// same set. a stalled m_axis holds the update stage and then s_axis.
// ----------------------------------------------------------------------------
`default_nettype none

module set_assoc_lru_tag_store
    import salru_pkg::*;
#(
    parameter int SETS = 64,
    parameter int WAYS = 8
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [ADDR_W-1:0]      s_axis_tdata,   // [63:0] line_address
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata    // outcome, victim_tag, pad
);

    localparam int SH    = $clog2(SETS + 1) - 1;
    localparam int TAG_W = ADDR_W - SH;
    localparam int IDX_W = (SETS > 1) ? $clog2(SETS) : 1;
    localparam logic [IDX_W-1:0] IDX_MASK = IDX_W'(SETS - 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SETS - 1);

    typedef logic [WAYS-1:0][TAG_W-1:0] row_t;

    // tag memory, one row per set, way 0 most recent
    row_t mem_q [SETS];

    logic               clr_busy_reg, clr_busy_next;
    logic [IDX_W-1:0]   clr_idx_reg, clr_idx_next;

    logic               s1_valid_reg, s1_valid_next;
    logic [IDX_W-1:0]   s1_idx_reg;
    logic [TAG_W-1:0]   s1_tag_reg;
    row_t               rd_row_reg;

    logic               wb_valid_reg;
    logic [IDX_W-1:0]   wb_idx_reg;
    row_t               wb_row_reg;

    logic               out_valid_reg, out_valid_next;
    outcome_t           out_outcome_reg;
    logic [VICTIM_W-1:0] out_victim_reg;

    logic               in_fire;
    logic               s1_fire;
    logic [IDX_W-1:0]   in_idx;
    row_t               cur_row;
    row_t               new_row;
    logic [WAYS-1:0]    match;
    logic [WAYS-1:0]    shift_en;
    logic               hit;
    logic [TAG_W-1:0]   last_tag;
    outcome_t           outcome;
    logic [VICTIM_W-1:0] victim;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_widx;
    row_t               mem_wdata;

    // handshake
    assign s1_fire       = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !clr_busy_reg && (!s1_valid_reg || s1_fire);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign in_idx        = s_axis_tdata[IDX_W-1:0] & IDX_MASK;

    // forward the row written at the read edge
    assign cur_row = (wb_valid_reg && (wb_idx_reg == s1_idx_reg)) ? wb_row_reg : rd_row_reg;

    // parallel way compare
    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            match[w] = (cur_row[w] == s1_tag_reg);
        end
    end

    // ways up to the first hit move down one place
    always_comb
    begin
        logic seen;
        seen = 1'b0;
        for (int w = 0; w < WAYS; w++)
        begin
            shift_en[w] = !seen;
            seen        = seen | match[w];
        end
    end

    // updated row, new tag in front
    always_comb
    begin
        new_row[0] = s1_tag_reg;
        for (int w = 1; w < WAYS; w++)
        begin
            new_row[w] = shift_en[w] ? cur_row[w-1] : cur_row[w];
        end
    end

    // result classification
    assign hit      = |match;
    assign last_tag = cur_row[WAYS-1];

    always_comb
    begin
        priority if (hit)
        begin
            outcome = OUTCOME_HIT;
            victim  = '0;
        end
        else if (last_tag != '0)
        begin
            outcome = OUTCOME_EVICT;
            victim  = VICTIM_W'(last_tag);
        end
        else
        begin
            outcome = OUTCOME_MISS;
            victim  = '0;
        end
    end

    // memory write port: clearing pass or write-back
    always_comb
    begin
        if (clr_busy_reg)
        begin
            mem_we    = 1'b1;
            mem_widx  = clr_idx_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = s1_fire;
            mem_widx  = s1_idx_reg;
            mem_wdata = new_row;
        end
    end

    // memory array
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_q[mem_widx] <= mem_wdata;
        end
        if (in_fire)
        begin
            rd_row_reg <= mem_q[in_idx];
        end
    end

    // clearing pass control
    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_idx_next  = clr_idx_reg;
        if (clr_busy_reg)
        begin
            if (clr_idx_reg == IDX_LAST)
            begin
                clr_busy_next = 1'b0;
            end
            else
            begin
                clr_idx_next = clr_idx_reg + IDX_W'(1);
            end
        end
    end

    // stage and output valid control
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg  <= 1'b1;
            clr_idx_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            wb_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clr_busy_reg  <= clr_busy_next;
            clr_idx_reg   <= clr_idx_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_fire)
            begin
                wb_valid_reg <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_idx_reg <= in_idx;
            s1_tag_reg <= s_axis_tdata[ADDR_W-1:SH];
        end
        if (s1_fire)
        begin
            wb_idx_reg      <= s1_idx_reg;
            wb_row_reg      <= new_row;
            out_outcome_reg <= outcome;
            out_victim_reg  <= victim;
        end
    end

    // output word
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_victim_reg, out_outcome_reg};

endmodule

`default_nettype wire
